### sv/lctd_pkg.sv
`default_nettype none

package lctd_pkg;

    // Biased local time word: standard or summer time plus two days, never negative
    localparam int U_W = 33;

    // Two days of bias keep the lowest local time above zero
    localparam logic [U_W-1:0] BIAS_SECS   = 33'd172800;
    localparam logic [U_W-1:0] SUMMER_SECS = 33'd3600;
    localparam logic [17:0]    SECS_PER_MIN = 18'd60;

    typedef enum logic [2:0] {
        REG_OFFSET_MINUTES   = 3'd0,
        REG_DST_ENABLE       = 3'd1,
        REG_DST_START_MONTH  = 3'd2,
        REG_DST_STOP_MONTH   = 3'd3,
        REG_START_MONTH_DAYS = 3'd4,
        REG_STOP_MONTH_DAYS  = 3'd5,
        REG_SWITCH_HOUR      = 3'd6,
        REG_UNUSED           = 3'd7
    } lctd_reg_idx_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  wday;
    } lctd_civil_t;

    typedef struct packed {
        logic       enable;
        logic [3:0] start_month;
        logic [3:0] stop_month;
        logic [4:0] start_days;
        logic [4:0] stop_days;
        logic [4:0] switch_hour;
    } lctd_dst_cfg_t;

endpackage

`default_nettype wire

### sv/lctd_civil.sv
`default_nettype none

module lctd_civil
    import lctd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [U_W-1:0]    in_u,
    output logic                   out_valid,
    output lctd_civil_t            out_civ
);

    // Exact reciprocals: floor(x / D) = (x * M) >> K over the whole input range
    localparam logic [26:0] M_DAY  = 27'(((64'd1 << 36) + 64'd674) / 64'd675);
    localparam logic [17:0] M_WEEK = 18'(((64'd1 << 20) + 64'd6) / 64'd7);
    localparam logic [17:0] M_MINS = 18'(((64'd1 << 23) + 64'd59) / 64'd60);
    localparam logic [11:0] M_HRS  = 12'(((64'd1 << 17) + 64'd59) / 64'd60);
    localparam logic [18:0] M_1460 = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] M_365  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);

    // Day of year, counted from 1 March, at which each month begins
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    localparam logic [19:0] DAYS_TO_0300  = 20'd719466;  // epoch shift minus bias days
    localparam logic [19:0] ERA4_START    = 20'd584388;
    localparam logic [19:0] ERA5_START    = 20'd730485;

    logic [8:0] v_reg;

    // stage 1
    logic [U_W-1:0] s1_u_reg;
    logic [52:0]    s1_p_reg;
    // stage 2
    logic [16:0]    s2_qd_reg, s2_qd_next;
    logic [16:0]    s2_sod_reg, s2_sod_next;
    // stage 3
    logic [17:0]    s3_doe_reg, s3_doe_next;
    logic           s3_era5_reg, s3_era5_next;
    logic [16:0]    s3_wdx_reg, s3_wdx_next;
    logic [34:0]    s3_pw_reg, s3_pw_next;
    logic [16:0]    s3_sod_reg;
    logic [34:0]    s3_pm_reg, s3_pm_next;
    // stage 4
    logic [17:0]    s4_doe_reg;
    logic           s4_era5_reg;
    logic [2:0]     s4_wd_reg, s4_wd_next;
    logic [10:0]    s4_mt_reg, s4_mt_next;
    logic [5:0]     s4_sec_reg, s4_sec_next;
    logic [36:0]    s4_p1460_reg, s4_p1460_next;
    logic [2:0]     s4_cent_reg, s4_cent_next;
    logic           s4_last_reg, s4_last_next;
    // stage 5
    logic [17:0]    s5_doe_reg;
    logic           s5_era5_reg;
    logic [2:0]     s5_wd_reg;
    logic [10:0]    s5_mt_reg;
    logic [5:0]     s5_sec_reg;
    logic [17:0]    s5_a_reg, s5_a_next;
    logic [22:0]    s5_ph_reg, s5_ph_next;
    // stage 6
    logic [17:0]    s6_doe_reg;
    logic           s6_era5_reg;
    logic [2:0]     s6_wd_reg;
    logic [4:0]     s6_hour_reg, s6_hour_next;
    logic [5:0]     s6_min_reg, s6_min_next;
    logic [5:0]     s6_sec_reg;
    logic [36:0]    s6_py_reg, s6_py_next;
    // stage 7
    logic [8:0]     s7_yoe_reg, s7_yoe_next;
    logic [8:0]     s7_doy_reg, s7_doy_next;
    logic           s7_era5_reg;
    logic [2:0]     s7_wd_reg;
    logic [4:0]     s7_hour_reg;
    logic [5:0]     s7_min_reg;
    logic [5:0]     s7_sec_reg;
    // stage 8
    logic [3:0]     s8_mp_reg, s8_mp_next;
    logic [8:0]     s8_doy_reg;
    logic [8:0]     s8_yoe_reg;
    logic           s8_era5_reg;
    logic [2:0]     s8_wd_reg;
    logic [4:0]     s8_hour_reg;
    logic [5:0]     s8_min_reg;
    logic [5:0]     s8_sec_reg;
    // stage 9
    lctd_civil_t    s9_civ_reg, s9_civ_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[7:0], in_valid};
        end
    end

    // Days since the biased start and second of day: divide by 128 * 675
    always_comb
    begin
        logic [26:0] qd_x;
        logic [25:0] rem;
        s2_qd_next  = s1_p_reg[52:36];
        qd_x        = 27'(s2_qd_next) * 27'd675;
        rem         = 26'(27'(s1_u_reg[U_W-1:7]) - qd_x);
        s2_sod_next = {rem[9:0], s1_u_reg[6:0]};
    end

    always_comb
    begin
        logic [19:0] z;
        z            = 20'(s2_qd_reg) + DAYS_TO_0300;
        s3_era5_next = (z >= ERA5_START);
        s3_doe_next  = 18'(z - (s3_era5_next ? ERA5_START : ERA4_START));
        s3_wdx_next  = s2_qd_reg + 17'd2;
        s3_pw_next   = 35'(s3_wdx_next) * 35'(M_WEEK);
        s3_pm_next   = 35'(s2_sod_reg) * 35'(M_MINS);
    end

    always_comb
    begin
        logic [16:0] wq7;
        logic [16:0] mt60;
        wq7           = 17'(s3_pw_reg[34:20]) * 17'd7;
        s4_wd_next    = 3'(s3_wdx_reg - wq7);
        s4_mt_next    = s3_pm_reg[33:23];
        mt60          = 17'(s4_mt_next) * 17'd60;
        s4_sec_next   = 6'(s3_sod_reg - mt60);
        s4_p1460_next = 37'(s3_doe_reg) * 37'(M_1460);
        s4_cent_next  = 3'(s3_doe_reg >= 18'd36524) + 3'(s3_doe_reg >= 18'd73048)
                      + 3'(s3_doe_reg >= 18'd109572) + 3'(s3_doe_reg >= 18'd146096);
        s4_last_next  = (s3_doe_reg == 18'd146096);
    end

    always_comb
    begin
        s5_a_next  = s4_doe_reg - 18'(s4_p1460_reg[36:29]) + 18'(s4_cent_reg)
                   - 18'(s4_last_reg);
        s5_ph_next = 23'(s4_mt_reg) * 23'(M_HRS);
    end

    always_comb
    begin
        logic [10:0] hr60;
        s6_py_next   = 37'(s5_a_reg) * 37'(M_365);
        s6_hour_next = s5_ph_reg[21:17];
        hr60         = 11'(s6_hour_next) * 11'd60;
        s6_min_next  = 6'(s5_mt_reg - hr60);
    end

    always_comb
    begin
        logic [1:0]  c100;
        logic [17:0] ydays;
        s7_yoe_next = s6_py_reg[35:27];
        c100        = 2'(s7_yoe_next >= 9'd100) + 2'(s7_yoe_next >= 9'd200)
                    + 2'(s7_yoe_next >= 9'd300);
        ydays       = 18'(s7_yoe_next) * 18'd365 + 18'(s7_yoe_next[8:2]) - 18'(c100);
        s7_doy_next = 9'(s6_doe_reg - ydays);
    end

    always_comb
    begin
        s8_mp_next = '0;
        for (int k = 1; k < 12; k++)
        begin
            s8_mp_next = s8_mp_next + 4'(s7_doy_reg >= MONTH_START[k]);
        end
    end

    // Months counted from March: January and February belong to the next year
    always_comb
    begin
        logic jan_feb;
        jan_feb            = (s8_mp_reg >= 4'd10);
        s9_civ_next.day    = 5'(s8_doy_reg - MONTH_START[s8_mp_reg] + 9'd1);
        s9_civ_next.month  = jan_feb ? s8_mp_reg - 4'd9 : s8_mp_reg + 4'd3;
        s9_civ_next.year   = (s8_era5_reg ? 12'd2000 : 12'd1600) + 12'(s8_yoe_reg)
                           + 12'(jan_feb);
        s9_civ_next.hour   = s8_hour_reg;
        s9_civ_next.minute = s8_min_reg;
        s9_civ_next.second = s8_sec_reg;
        s9_civ_next.wday   = s8_wd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_u_reg     <= in_u;
            s1_p_reg     <= 53'(in_u[U_W-1:7]) * 53'(M_DAY);

            s2_qd_reg    <= s2_qd_next;
            s2_sod_reg   <= s2_sod_next;

            s3_doe_reg   <= s3_doe_next;
            s3_era5_reg  <= s3_era5_next;
            s3_wdx_reg   <= s3_wdx_next;
            s3_pw_reg    <= s3_pw_next;
            s3_sod_reg   <= s2_sod_reg;
            s3_pm_reg    <= s3_pm_next;

            s4_doe_reg   <= s3_doe_reg;
            s4_era5_reg  <= s3_era5_reg;
            s4_wd_reg    <= s4_wd_next;
            s4_mt_reg    <= s4_mt_next;
            s4_sec_reg   <= s4_sec_next;
            s4_p1460_reg <= s4_p1460_next;
            s4_cent_reg  <= s4_cent_next;
            s4_last_reg  <= s4_last_next;

            s5_doe_reg   <= s4_doe_reg;
            s5_era5_reg  <= s4_era5_reg;
            s5_wd_reg    <= s4_wd_reg;
            s5_mt_reg    <= s4_mt_reg;
            s5_sec_reg   <= s4_sec_reg;
            s5_a_reg     <= s5_a_next;
            s5_ph_reg    <= s5_ph_next;

            s6_doe_reg   <= s5_doe_reg;
            s6_era5_reg  <= s5_era5_reg;
            s6_wd_reg    <= s5_wd_reg;
            s6_hour_reg  <= s6_hour_next;
            s6_min_reg   <= s6_min_next;
            s6_sec_reg   <= s5_sec_reg;
            s6_py_reg    <= s6_py_next;

            s7_yoe_reg   <= s7_yoe_next;
            s7_doy_reg   <= s7_doy_next;
            s7_era5_reg  <= s6_era5_reg;
            s7_wd_reg    <= s6_wd_reg;
            s7_hour_reg  <= s6_hour_reg;
            s7_min_reg   <= s6_min_reg;
            s7_sec_reg   <= s6_sec_reg;

            s8_mp_reg    <= s8_mp_next;
            s8_doy_reg   <= s7_doy_reg;
            s8_yoe_reg   <= s7_yoe_reg;
            s8_era5_reg  <= s7_era5_reg;
            s8_wd_reg    <= s7_wd_reg;
            s8_hour_reg  <= s7_hour_reg;
            s8_min_reg   <= s7_min_reg;
            s8_sec_reg   <= s7_sec_reg;

            s9_civ_reg   <= s9_civ_next;
        end
    end

    assign out_valid = v_reg[8];
    assign out_civ   = s9_civ_reg;

endmodule

`default_nettype wire

### sv/lctd_dst.sv
`default_nettype none

module lctd_dst
    import lctd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire lctd_dst_cfg_t cfg,
    input  wire logic          in_valid,
    input  wire lctd_civil_t   civ_std,
    input  wire lctd_civil_t   civ_sum,
    output logic               out_valid,
    output logic               out_summer,
    output lctd_civil_t        out_civ
);

    // Last Sunday from the month length register; a short length may wrap below zero
    function automatic logic [7:0] last_sunday(logic [4:0] day, logic [2:0] wd,
                                               logic [4:0] mdays);
        logic [5:0] ns;
        logic [5:0] diff;
        logic [5:0] add7;
        logic [7:0] ls;
        ns = 6'(day) + 6'd7 - 6'(wd);
        if (ns <= 6'(mdays))
        begin
            diff = 6'(mdays) - ns;
            if (diff >= 6'd28)
                add7 = 6'd28;
            else if (diff >= 6'd21)
                add7 = 6'd21;
            else if (diff >= 6'd14)
                add7 = 6'd14;
            else if (diff >= 6'd7)
                add7 = 6'd7;
            else
                add7 = 6'd0;
            ls = 8'(ns + add7);
        end
        else
        begin
            ls = 8'(ns) - 8'd7;
        end
        return ls;
    endfunction

    logic        v_reg;
    logic [7:0]  ls_start_reg;
    logic [7:0]  ls_stop_reg;
    lctd_civil_t std_reg;
    lctd_civil_t sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ls_start_reg <= last_sunday(civ_std.day, civ_std.wday, cfg.start_days);
            ls_stop_reg  <= last_sunday(civ_std.day, civ_std.wday, cfg.stop_days);
            std_reg      <= civ_std;
            sum_reg      <= civ_sum;
        end
    end

    always_comb
    begin
        logic [7:0] day8;
        logic       hour_on;
        day8    = 8'(std_reg.day);
        hour_on = (std_reg.hour >= cfg.switch_hour);
        if (!cfg.enable)
            out_summer = 1'b0;
        else if (std_reg.month < cfg.start_month || std_reg.month > cfg.stop_month)
            out_summer = 1'b0;
        else if (std_reg.month == cfg.start_month)
            out_summer = (day8 > ls_start_reg) || (day8 == ls_start_reg && hour_on);
        else if (std_reg.month == cfg.stop_month)
            out_summer = (day8 < ls_stop_reg) || (day8 == ls_stop_reg && !hour_on);
        else
            out_summer = 1'b1;
    end

    assign out_valid = v_reg;
    assign out_civ   = out_summer ? sum_reg : std_reg;

endmodule

`default_nettype wire

### sv/local_calendar_time_with_dst_top.sv
`default_nettype none

// Channel   Direction  Handshake             Payload
// --------  ---------  --------------------  ---------------------------------------
// input     in         in_valid / in_ready   utc_seconds
// output    out        out_valid / out_ready year, month, day, hour, minute, second,
//                                            date_word, time_word, summer_flag
// config    in         cfg_we (no wait)      cfg_index, cfg_data
//
// One transaction per cycle sustained while out_ready keeps the output from stalling.
// Input reaches the output through one entry stage, the civil-date pipeline of nine
// stages of constant reciprocal multiplies, one last-Sunday stage and the output register.
// Reset clears all valid bits and loads the register reset values; no sweep needed.
// A stall on the output freezes every stage at once, so in_ready follows out_ready
// whenever the output register is full.

module local_calendar_time_with_dst_top
    import lctd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [11:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] utc_seconds,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [11:0]      year,
    output logic [3:0]       month,
    output logic [4:0]       day,
    output logic [4:0]       hour,
    output logic [5:0]       minute,
    output logic [5:0]       second,
    output logic [15:0]      date_word,
    output logic [15:0]      time_word,
    output logic             summer_flag
);

    // ---------------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------------
    logic signed [11:0] offset_minutes_reg;
    lctd_dst_cfg_t      dst_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_minutes_reg      <= '0;
            dst_cfg_reg.enable      <= 1'b0;
            dst_cfg_reg.start_month <= 4'd3;
            dst_cfg_reg.stop_month  <= 4'd10;
            dst_cfg_reg.start_days  <= 5'd31;
            dst_cfg_reg.stop_days   <= 5'd31;
            dst_cfg_reg.switch_hour <= 5'd1;
        end
        else if (cfg_we)
        begin
            case (lctd_reg_idx_t'(cfg_index))
                REG_OFFSET_MINUTES:   offset_minutes_reg      <= cfg_data;
                REG_DST_ENABLE:       dst_cfg_reg.enable      <= cfg_data[0];
                REG_DST_START_MONTH:  dst_cfg_reg.start_month <= cfg_data[3:0];
                REG_DST_STOP_MONTH:   dst_cfg_reg.stop_month  <= cfg_data[3:0];
                REG_START_MONTH_DAYS: dst_cfg_reg.start_days  <= cfg_data[4:0];
                REG_STOP_MONTH_DAYS:  dst_cfg_reg.stop_days   <= cfg_data[4:0];
                REG_SWITCH_HOUR:      dst_cfg_reg.switch_hour <= cfg_data[4:0];
                default:              ;
            endcase
        end
    end

    // ---------------------------------------------------------------------------
    // Pipeline advance: everything moves unless the output register is held
    // ---------------------------------------------------------------------------
    logic out_valid_reg;
    logic en;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ---------------------------------------------------------------------------
    // Entry stage: standard local time and the same plus one hour, both biased
    // by two days so the civil pipelines only ever see non-negative values
    // ---------------------------------------------------------------------------
    logic signed [17:0] off_secs;
    logic [U_W-1:0]     u_std_next;
    logic               v0_reg;
    logic [U_W-1:0]     u_std_reg;
    logic [U_W-1:0]     u_sum_reg;

    always_comb
    begin
        off_secs   = 18'(offset_minutes_reg) * $signed(SECS_PER_MIN);
        u_std_next = 33'(utc_seconds) + 33'(off_secs) + BIAS_SECS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_std_reg <= u_std_next;
            u_sum_reg <= u_std_next + SUMMER_SECS;
        end
    end

    // ---------------------------------------------------------------------------
    // Two civil converters side by side: standard time feeds the summer rule,
    // the shifted copy is ready in case the rule says summer
    // ---------------------------------------------------------------------------
    logic        civ_std_v;
    logic        civ_sum_v;
    lctd_civil_t civ_std;
    lctd_civil_t civ_sum;

    lctd_civil u_civil_std (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v0_reg),
        .in_u      (u_std_reg),
        .out_valid (civ_std_v),
        .out_civ   (civ_std)
    );

    lctd_civil u_civil_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v0_reg),
        .in_u      (u_sum_reg),
        .out_valid (civ_sum_v),
        .out_civ   (civ_sum)
    );

    // ---------------------------------------------------------------------------
    // Last-Sunday rule and selection of the matching conversion
    // ---------------------------------------------------------------------------
    logic        sel_v;
    logic        sel_summer;
    lctd_civil_t sel_civ;

    lctd_dst u_dst (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .cfg        (dst_cfg_reg),
        .in_valid   (civ_std_v && civ_sum_v),
        .civ_std    (civ_std),
        .civ_sum    (civ_sum),
        .out_valid  (sel_v),
        .out_summer (sel_summer),
        .out_civ    (sel_civ)
    );

    // ---------------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------------
    lctd_civil_t out_civ_reg;
    logic        summer_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= sel_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_civ_reg <= sel_civ;
            summer_reg  <= sel_summer;
        end
    end

    assign out_valid   = out_valid_reg;
    assign year        = out_civ_reg.year;
    assign month       = out_civ_reg.month;
    assign day         = out_civ_reg.day;
    assign hour        = out_civ_reg.hour;
    assign minute      = out_civ_reg.minute;
    assign second      = out_civ_reg.second;
    assign date_word   = {4'd0, out_civ_reg.month, 3'd0, out_civ_reg.day};
    assign time_word   = {3'd0, out_civ_reg.hour, 2'd0, out_civ_reg.minute};
    assign summer_flag = summer_reg;

`ifndef SYNTHESIS
    // Both converters share one valid chain in spirit; they must never drift apart
    a_conv_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        civ_std_v == civ_sum_v)
        else $error("civil converters out of step");

    // Any biased input word must land on a legal calendar date and time of day
    a_out_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_civ_reg.month >= 4'd1 && out_civ_reg.month <= 4'd12
                           && out_civ_reg.day >= 5'd1 && out_civ_reg.hour <= 5'd23
                           && out_civ_reg.minute <= 6'd59 && out_civ_reg.second <= 6'd59))
        else $error("illegal calendar fields at output");
`endif

endmodule

`default_nettype wire

### verif/local_calendar_time_with_dst_top_tb.sv
`default_nettype none

module local_calendar_time_with_dst_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lctd_pkg::*;

    // Register set as the block holds it after a write (upper data bits masked off).
    typedef struct {
        logic signed [11:0] offset;
        logic               enable;
        logic [3:0]         start_month;
        logic [3:0]         stop_month;
        logic [4:0]         start_days;
        logic [4:0]         stop_days;
        logic [4:0]         switch_hour;
    } cal_cfg_t;

    // One result transaction, in port order.
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [15:0] date_word;
        logic [15:0] time_word;
        logic        summer_flag;
    } cal_result_t;

    // Broken-down time at full precision, before truncation to port widths.
    typedef struct {
        longint year;
        longint month;
        longint day;
        longint hour;
        longint minute;
        longint second;
        longint wday;
    } cal_fields_t;

    typedef struct {
        logic [31:0] utc;
        cal_result_t calendar;
    } awaited_t;

    // ------------------------------------------------------------------
    // Scoreboard: keeps its own register copy, converts each accepted UTC
    // count to the expected calendar and checks results in order.
    // ------------------------------------------------------------------
    class calendar_scoreboard;
        cal_cfg_t    regs;
        awaited_t    awaited_dates[$];
        int unsigned faults;

        function new();
            regs.offset      = '0;
            regs.enable      = 1'b0;
            regs.start_month = 4'd3;
            regs.stop_month  = 4'd10;
            regs.start_days  = 5'd31;
            regs.stop_days   = 5'd31;
            regs.switch_hour = 5'd1;
            faults           = 0;
        endfunction

        function void write_reg(lctd_reg_idx_t idx, logic [11:0] data);
            case (idx)
                REG_OFFSET_MINUTES:   regs.offset      = data;
                REG_DST_ENABLE:       regs.enable      = data[0];
                REG_DST_START_MONTH:  regs.start_month = data[3:0];
                REG_DST_STOP_MONTH:   regs.stop_month  = data[3:0];
                REG_START_MONTH_DAYS: regs.start_days  = data[4:0];
                REG_STOP_MONTH_DAYS:  regs.stop_days   = data[4:0];
                REG_SWITCH_HOUR:      regs.switch_hour = data[4:0];
                default: ;
            endcase
        endfunction

        // Seconds (may be negative) to proleptic Gregorian fields.
        function cal_fields_t split_seconds(longint t);
            cal_fields_t f;
            longint days, sod, z, era, doe, yoe, doy, mp, wd;
            days = t / 86400;
            sod  = t % 86400;
            if (sod < 0)
            begin
                sod  += 86400;
                days -= 1;
            end
            f.hour   = sod / 3600;
            f.minute = (sod / 60) % 60;
            f.second = sod % 60;
            wd = (days + 4) % 7;
            if (wd < 0)
                wd += 7;
            f.wday  = wd;
            z       = days + 719468;
            era     = (z >= 0 ? z : z - 146096) / 146097;
            doe     = z - era * 146097;
            yoe     = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            doy     = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp      = (5 * doy + 2) / 153;
            f.day   = doy - (153 * mp + 2) / 5 + 1;
            f.month = mp < 10 ? mp + 3 : mp - 9;
            f.year  = yoe + era * 400 + (f.month <= 2 ? 1 : 0);
            return f;
        endfunction

        // Last Sunday from the register month length; overshoot steps back a
        // week and is held as an 8-bit value.
        function longint last_sunday(longint mday, longint wday, longint mdays);
            longint next_sun;
            next_sun = mday + (7 - wday);
            if (next_sun <= mdays)
                return next_sun + 7 * ((mdays - next_sun) / 7);
            return (next_sun - 7) & 64'hFF;
        endfunction

        function bit summer_time(cal_fields_t f);
            longint ls;
            if (!(f.month >= longint'(regs.start_month) && f.month <= longint'(regs.stop_month)))
                return 1'b0;
            if (f.month == longint'(regs.start_month))
            begin
                ls = last_sunday(f.day, f.wday, longint'(regs.start_days));
                if (f.day > ls)
                    return 1'b1;
                return f.day == ls && f.hour >= longint'(regs.switch_hour);
            end
            if (f.month == longint'(regs.stop_month))
            begin
                ls = last_sunday(f.day, f.wday, longint'(regs.stop_days));
                if (f.day < ls)
                    return 1'b1;
                return f.day == ls && f.hour < longint'(regs.switch_hour);
            end
            return 1'b1;
        endfunction

        function cal_result_t convert_utc(logic [31:0] utc);
            cal_result_t r;
            cal_fields_t f;
            longint      t;
            bit          summer;
            t      = longint'(utc) + longint'(regs.offset) * 60;
            summer = 1'b0;
            if (regs.enable)
            begin
                summer = summer_time(split_seconds(t));
                if (summer)
                    t += 3600;
            end
            f             = split_seconds(t);
            r.year        = f.year[11:0];
            r.month       = f.month[3:0];
            r.day         = f.day[4:0];
            r.hour        = f.hour[4:0];
            r.minute      = f.minute[5:0];
            r.second      = f.second[5:0];
            r.date_word   = {f.month[7:0], f.day[7:0]};
            r.time_word   = {f.hour[7:0], f.minute[7:0]};
            r.summer_flag = summer;
            return r;
        endfunction

        function void note_utc(logic [31:0] utc);
            awaited_t a;
            a.utc      = utc;
            a.calendar = convert_utc(utc);
            awaited_dates.push_back(a);
        endfunction

        function void check_calendar(cal_result_t got);
            awaited_t    a;
            cal_result_t e;
            if (awaited_dates.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("result with no transaction outstanding: %0d-%0d-%0d",
                             got.year, got.month, got.day);
                return;
            end
            a = awaited_dates.pop_front();
            e = a.calendar;
            if (got.year !== e.year || got.month !== e.month || got.day !== e.day ||
                got.hour !== e.hour || got.minute !== e.minute ||
                got.second !== e.second || got.date_word !== e.date_word ||
                got.time_word !== e.time_word || got.summer_flag !== e.summer_flag)
            begin
                faults++;
                if (faults <= 10)
                begin
                    $display("mismatch utc=%0d", a.utc);
                    $display("  expected %0d-%0d-%0d %0d:%0d:%0d dw=%h tw=%h s=%0d",
                             e.year, e.month, e.day, e.hour, e.minute, e.second,
                             e.date_word, e.time_word, e.summer_flag);
                    $display("  got      %0d-%0d-%0d %0d:%0d:%0d dw=%h tw=%h s=%0d",
                             got.year, got.month, got.day, got.hour, got.minute,
                             got.second, got.date_word, got.time_word, got.summer_flag);
                end
            end
        endfunction

        function int pending();
            return awaited_dates.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value.
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [2:0]  cfg_index   = '0;
    logic [11:0] cfg_data    = '0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [31:0] utc_seconds = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [15:0] date_word;
    logic [15:0] time_word;
    logic        summer_flag;

    calendar_scoreboard sb;
    cal_cfg_t           cur_cfg;        // settings the stimulus aims at
    bit                 idle_mode = 1'b1;
    int unsigned        results_seen = 0;

    local_calendar_time_with_dst_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .utc_seconds (utc_seconds),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .year        (year),
        .month       (month),
        .day         (day),
        .hour        (hour),
        .minute      (minute),
        .second      (second),
        .date_word   (date_word),
        .time_word   (time_word),
        .summer_flag (summer_flag)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a correct run takes well under a tenth of this.
    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Day number since 1970-01-01 of a civil date.
    function automatic longint days_from_civil(int y, int m, int d);
        longint yy, era, yoe, doy, doe;
        yy  = (m <= 2) ? y - 1 : y;
        era = (yy >= 0 ? yy : yy - 399) / 400;
        yoe = yy - era * 400;
        doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    // UTC count whose standard local time (current offset) is the given
    // moment; falls back to a random count when that lies outside 32 bits.
    function automatic logic [31:0] make_utc(longint days, int hh, int mm, int ss);
        longint lt;
        lt = days * 86400 + hh * 3600 + mm * 60 + ss - longint'(cur_cfg.offset) * 60;
        if (lt < 0 || lt > 64'sd4294967295)
            return $urandom;
        return lt[31:0];
    endfunction

    function automatic cal_cfg_t mk_cfg(int off, bit en, int sm, int pm, int sd, int pd,
                                        int sh);
        cal_cfg_t c;
        c.offset      = 12'(off);
        c.enable      = en;
        c.start_month = 4'(sm);
        c.stop_month  = 4'(pm);
        c.start_days  = 5'(sd);
        c.stop_days   = 5'(pd);
        c.switch_hour = 5'(sh);
        return c;
    endfunction

    // Corner settings first: season wrapped, one-month season, out-of-range
    // months, odd month lengths, switch hours past the day.
    function automatic cal_cfg_t corner_cfg(int k);
        case (k)
            0:       return mk_cfg(2047, 1'b1, 10, 3, 30, 28, 0);
            1:       return mk_cfg(-2048, 1'b1, 4, 4, 28, 31, 23);
            2:       return mk_cfg(1440, 1'b1, 0, 15, 0, 31, 31);
            3:       return mk_cfg(-1440, 1'b1, 1, 12, 31, 0, 24);
            default: return mk_cfg(0, 1'b0, 12, 1, 29, 29, 12);
        endcase
    endfunction

    function automatic cal_cfg_t rand_cfg();
        int off, sm, pm, sd, pd, sh;
        case ($urandom_range(0, 7))
            0:       off = -2048;
            1:       off = 2047;
            2:       off = -1440;
            3:       off = 1440;
            4:       off = 60 * ($urandom_range(0, 24) - 12);
            default: off = int'($urandom_range(0, 2880)) - 1440;
        endcase
        sm = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 15);
        if ($urandom_range(0, 4) < 3)
        begin
            pm = sm + $urandom_range(0, 9);
            if (pm > 12)
                pm = 12;
        end
        else
            pm = $urandom_range(0, 15);
        sd = ($urandom_range(0, 6) != 0) ? $urandom_range(28, 31) : $urandom_range(0, 31);
        pd = ($urandom_range(0, 6) != 0) ? $urandom_range(28, 31) : $urandom_range(0, 31);
        sh = ($urandom_range(0, 6) != 0) ? $urandom_range(0, 23) : $urandom_range(0, 31);
        return mk_cfg(off, $urandom_range(0, 5) != 0, sm, pm, sd, pd, sh);
    endfunction

    // Mostly moments close to a season switch, the rest noise and edges.
    function automatic logic [31:0] pick_utc();
        int     sel, m, y, h, mm, ss, r;
        longint lt;
        sel = $urandom_range(0, 99);
        if (sel < 60)
        begin
            m = $urandom_range(0, 1) ? cur_cfg.start_month : cur_cfg.stop_month;
            if (m < 1 || m > 12)
                m = $urandom_range(1, 12);
            y = $urandom_range(1970, 2105);
            if (cur_cfg.switch_hour < 24 && $urandom_range(0, 2) != 0)
            begin
                r = $urandom_range(0, 2);
                h = int'(cur_cfg.switch_hour) + r - 1;
                if (h < 0)
                    h = 0;
                if (h > 23)
                    h = 23;
            end
            else
                h = $urandom_range(0, 23);
            case ($urandom_range(0, 3))
                0:       begin mm = 59; ss = 59; end
                1:       begin mm = 0;  ss = 0;  end
                default: begin mm = $urandom_range(0, 59); ss = $urandom_range(0, 59); end
            endcase
            r = $urandom_range(17, 31);
            return make_utc(days_from_civil(y, m, 1) + r, h, mm, ss);
        end
        if (sel < 85)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 200000);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 200000);
            2:
            begin
                lt = longint'($urandom_range(0, 49709)) * 86400;
                if ($urandom_range(0, 1))
                    lt += 86399;
                return lt[31:0];
            end
            default:
            begin
                r = $urandom_range(0, 1);
                return make_utc(days_from_civil($urandom_range(1970, 2105),
                                                $urandom_range(1, 12), 1) - r, 0, 0, 0);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------

    // Writes every index, unused one included, with junk in the bits above
    // each register's width.  Only called with the block idle.
    task automatic apply_settings(input cal_cfg_t s);
        lctd_reg_idx_t idx;
        logic [11:0]   data;
        for (int i = 0; i < 8; i++)
        begin
            idx  = lctd_reg_idx_t'(i);
            data = 12'($urandom);
            case (idx)
                REG_OFFSET_MINUTES:   data       = s.offset;
                REG_DST_ENABLE:       data[0]    = s.enable;
                REG_DST_START_MONTH:  data[3:0]  = s.start_month;
                REG_DST_STOP_MONTH:   data[3:0]  = s.stop_month;
                REG_START_MONTH_DAYS: data[4:0]  = s.start_days;
                REG_STOP_MONTH_DAYS:  data[4:0]  = s.stop_days;
                REG_SWITCH_HOUR:      data[4:0]  = s.switch_hour;
                default: ;
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
            sb.write_reg(idx, data);
        end
        cfg_we  <= 1'b0;
        cur_cfg  = s;
    endtask

    // Offers one transaction, with an occasional idle burst in front of it.
    // valid is only ever assigned once per time step.
    task automatic send_utc(input logic [31:0] v);
        if (idle_mode && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        utc_seconds <= v;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_utc(v);
    endtask

    // Lets every outstanding transaction come out, then a latency's worth more.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure bursts, plus one long hold-off once
    // a few hundred results are through, so the pipeline fills and in_ready
    // drops while the sender keeps offering.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        cal_result_t got;
        int          hold_left;
        bit          pressure_done;
        hold_left     = 0;
        pressure_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = {year, month, day, hour, minute, second, date_word, time_word,
                       summer_flag};
                sb.check_calendar(got);
                results_seen++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!pressure_done && results_seen >= 400)
            begin
                pressure_done = 1'b1;
                hold_left     = 149;
                out_ready    <= 1'b0;
            end
            else if (idle_mode && $urandom_range(0, 9) == 0)
            begin
                hold_left  = $urandom_range(0, 15);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        sb      = new();
        cur_cfg = mk_cfg(0, 1'b0, 3, 10, 31, 31, 1);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register reset values, summer time off: range ends, a leap day and the non-leap 2100.
        send_utc(32'h0000_0000);
        send_utc(32'hFFFF_FFFF);
        send_utc(32'h8000_0000);
        send_utc(make_utc(days_from_civil(2000, 2, 29), 12, 0, 0));
        send_utc(make_utc(days_from_civil(2100, 2, 28), 23, 59, 59));
        drain_block();

        // Central European rule around both switches of 2021.
        apply_settings(mk_cfg(60, 1'b1, 3, 10, 31, 31, 1));
        send_utc(make_utc(days_from_civil(2021, 3, 28), 0, 59, 59));
        send_utc(make_utc(days_from_civil(2021, 3, 28), 1, 0, 0));
        send_utc(make_utc(days_from_civil(2021, 3, 27), 12, 0, 0));
        send_utc(make_utc(days_from_civil(2021, 3, 31), 23, 59, 59));
        send_utc(make_utc(days_from_civil(2021, 10, 31), 0, 59, 59));
        send_utc(make_utc(days_from_civil(2021, 10, 31), 1, 0, 0));
        send_utc(make_utc(days_from_civil(2021, 10, 30), 12, 0, 0));
        send_utc(make_utc(days_from_civil(2021, 7, 1), 12, 0, 0));
        send_utc(make_utc(days_from_civil(2021, 1, 10), 12, 0, 0));
        send_utc(make_utc(days_from_civil(2021, 11, 15), 12, 0, 0));
        drain_block();

        // Most negative offset pulls the epoch back into 1969.
        apply_settings(mk_cfg(-2048, 1'b1, 3, 10, 31, 31, 1));
        send_utc(32'd0);
        send_utc(32'd3599);
        drain_block();

        // Most positive offset carries the top of the count into 2106.
        apply_settings(mk_cfg(2047, 1'b1, 3, 10, 31, 31, 1));
        send_utc(32'hFFFF_FFFF);
        drain_block();

        // Random part: corner settings first, then random ones; the last
        // phase runs with no idling on either side.
        for (int ph = 0; ph < 12; ph++)
        begin
            apply_settings(ph < 5 ? corner_cfg(ph) : rand_cfg());
            if (ph == 11)
                idle_mode = 1'b0;
            for (int n = 0; n < 170; n++)
                send_utc(pick_utc());
            drain_block();
        end

        if (sb.pending() != 0)
            $display("%0d transactions never produced a result", sb.pending());
        if (sb.faults == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
